/* design/affine_trs_world_transform_macros.svh */
// ---------------------------------------------------------------------------
// affine trs world transform assertion macros
// shared assertion helpers for the world transform pipeline
// ---------------------------------------------------------------------------
`ifndef AFFINE_TRS_WORLD_TRANSFORM_MACROS_SVH
`define AFFINE_TRS_WORLD_TRANSFORM_MACROS_SVH
`ifndef SYNTH
`define ATW_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ATW_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ATW_ASSERT(label, clk, rst_n, prop)
`define ATW_ASSERT_NORST(label, clk, prop)
`endif
`endif

/* design/atw_pkg.sv */
// ---------------------------------------------------------------------------
// atw_pkg
// constants and helpers for the world transform pipeline
// ---------------------------------------------------------------------------
package atw_pkg;
	localparam int SinA = 102944;
	localparam int SinB = 42047;
	localparam int SinC = 4639;
	localparam logic signed [31:0] QMax = 32'sh7fffffff;
	localparam logic signed [31:0] QMin = 32'sh80000000;

	// clamp a wide signed value to 32 bits
	function automatic logic [32:0] clamp(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > 66'(signed'(QMax))) r = {1'b1, QMax};
		else if (v < 66'(signed'(QMin))) r = {1'b1, QMin};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction
endpackage

/* design/affine_trs_world_transform.sv */
// ---------------------------------------------------------------------------
// affine_trs_world_transform
// builds a node's local trs matrix and composes it with the parent matrix
// ---------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_axis   in   tvalid / tready    tdata node fields, tuser is_root
// m_axis   out  tvalid / tready    tdata world matrix, tuser saturated
//
// nine register stages, one item per cycle while the output is free or taken
// the sine polynomial fills stages 1 to 6, with one multiply in each of stages 2 to 5
// all stages advance together while the output is free or taken
// reset clears only the valid bits
module affine_trs_world_transform (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// angle[15:0] scale_x scale_y pos_x pos_y par_a par_b par_tx par_d par_e par_ty
	input  logic [335:0] s_axis_tdata,
	// is_root
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_a out_b out_tx out_d out_e out_ty
	output logic [191:0] m_axis_tdata,
	// saturated
	output logic         m_axis_tuser
);
	`include "affine_trs_world_transform_macros.svh"

	localparam int NS = 9;
	logic [NS:1] v_q;
	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = v_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NS-1:1], s_axis_tvalid};
		end
	end

	// node payload carried along
	typedef struct packed {
		logic signed [31:0] sx, sy, px, py, pa, pb, ptx, pd, pe, pty;
		logic root;
	} node_t;

	node_t n_in;
	assign n_in = '{sx: s_axis_tdata[47:16], sy: s_axis_tdata[79:48],
		px: s_axis_tdata[111:80], py: s_axis_tdata[143:112],
		pa: s_axis_tdata[175:144], pb: s_axis_tdata[207:176],
		ptx: s_axis_tdata[239:208], pd: s_axis_tdata[271:240],
		pe: s_axis_tdata[303:272], pty: s_axis_tdata[335:304],
		root: s_axis_tuser};

	node_t n_s1, n_s2, n_s3, n_s4, n_s5, n_s6;

	// sine / cosine lanes: index 0 sine, 1 cosine
	logic [15:0] ang_in [2];
	assign ang_in[0] = s_axis_tdata[15:0];
	assign ang_in[1] = s_axis_tdata[15:0] + 16'h4000;

	logic [14:0] x_s1 [2];
	logic        neg_s1 [2], neg_s2 [2], neg_s3 [2], neg_s4 [2], neg_s5 [2];
	logic [14:0] x_s2 [2], x_s3 [2], x_s4 [2];
	logic [14:0] x2_s2 [2], x2_s3 [2];
	logic [15:0] t_s3 [2];
	logic [16:0] t_s4 [2];
	logic [16:0] y_s5 [2];
	logic signed [17:0] sc_s6 [2];

	for (genvar k = 0; k < 2; k++) begin : g_trig
		logic [14:0] xf;
		logic [29:0] sq;
		logic [28:0] m1;
		logic [31:0] m2;
		logic [31:0] m3;
		assign xf = ang_in[k][14] ? 15'(15'd16384 - {1'b0, ang_in[k][13:0]})
			: {1'b0, ang_in[k][13:0]};
		assign sq = x_s1[k] * x_s1[k];
		assign m1 = 29'(x2_s2[k]) * 29'(atw_pkg::SinC);
		assign m2 = 32'(t_s3[k]) * 32'(x2_s3[k]);
		assign m3 = 32'(t_s4[k]) * 32'(x_s4[k]);
		always_ff @(posedge clk) begin
			if (adv) begin
				x_s1[k] <= xf; neg_s1[k] <= ang_in[k][15];
				x_s2[k] <= x_s1[k]; neg_s2[k] <= neg_s1[k];
				x2_s2[k] <= sq[28:14];
				x_s3[k] <= x_s2[k]; neg_s3[k] <= neg_s2[k]; x2_s3[k] <= x2_s2[k];
				t_s3[k] <= 16'(atw_pkg::SinB - int'(m1[28:14]));
				x_s4[k] <= x_s3[k]; neg_s4[k] <= neg_s3[k];
				t_s4[k] <= 17'(atw_pkg::SinA - int'(m2[31:14]));
				neg_s5[k] <= neg_s4[k];
				y_s5[k] <= m3[30:14];
				sc_s6[k] <= neg_s5[k] ? -$signed({1'b0, y_s5[k]})
					: $signed({1'b0, y_s5[k]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1 <= n_in; n_s2 <= n_s1; n_s3 <= n_s2;
			n_s4 <= n_s3; n_s5 <= n_s4; n_s6 <= n_s5;
		end
	end

	// stage 7: local products and clamp
	logic signed [49:0] pla, plb, pld, ple;
	assign pla = sc_s6[1] * n_s6.sx;
	assign plb = sc_s6[0] * n_s6.sx;
	assign pld = -(sc_s6[0] * n_s6.sy);
	assign ple = sc_s6[1] * n_s6.sy;

	logic [32:0] ca, cb, cd, ce;
	assign ca = atw_pkg::clamp(66'(pla >>> 16));
	assign cb = atw_pkg::clamp(66'(plb >>> 16));
	assign cd = atw_pkg::clamp(66'(pld >>> 16));
	assign ce = atw_pkg::clamp(66'(ple >>> 16));

	logic signed [31:0] la_s7, lb_s7, ld_s7, le_s7;
	logic lsat_s7, lsat_s8, lsat_s9;
	node_t n_s7, n_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			la_s7 <= ca[31:0]; lb_s7 <= cb[31:0];
			ld_s7 <= cd[31:0]; le_s7 <= ce[31:0];
			lsat_s7 <= ca[32] | cb[32] | cd[32] | ce[32];
			n_s7 <= n_s6;
		end
	end

	// stage 8: twelve parent products
	logic signed [63:0] p_s8 [12];
	logic signed [31:0] la_s8, lb_s8, ld_s8, le_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s8[0]  <= n_s7.pa * la_s7; p_s8[1]  <= n_s7.pb * ld_s7;
			p_s8[2]  <= n_s7.pa * lb_s7; p_s8[3]  <= n_s7.pb * le_s7;
			p_s8[4]  <= n_s7.pa * n_s7.px; p_s8[5] <= n_s7.pb * n_s7.py;
			p_s8[6]  <= n_s7.pd * la_s7; p_s8[7]  <= n_s7.pe * ld_s7;
			p_s8[8]  <= n_s7.pd * lb_s7; p_s8[9]  <= n_s7.pe * le_s7;
			p_s8[10] <= n_s7.pd * n_s7.px; p_s8[11] <= n_s7.pe * n_s7.py;
			la_s8 <= la_s7; lb_s8 <= lb_s7; ld_s8 <= ld_s7; le_s8 <= le_s7;
			lsat_s8 <= lsat_s7; n_s8 <= n_s7;
		end
	end

	// stage 9: sums, floor, clamp, root select
	logic signed [31:0] loc [6];
	logic signed [31:0] addt [6];
	assign loc = '{la_s8, lb_s8, n_s8.px, ld_s8, le_s8, n_s8.py};
	assign addt = '{32'sd0, 32'sd0, n_s8.ptx, 32'sd0, 32'sd0, n_s8.pty};

	logic [191:0] w_s9;
	logic [5:0]   wsat;
	logic [191:0] w_c;
	for (genvar j = 0; j < 6; j++) begin : g_w
		logic signed [65:0] sum;
		logic [32:0] cw;
		assign sum = ((66'(p_s8[2*j]) + 66'(p_s8[2*j+1])) >>> 16) + 66'(addt[j]);
		assign cw = atw_pkg::clamp(sum);
		assign w_c[32*j +: 32] = n_s8.root ? loc[j] : cw[31:0];
		assign wsat[j] = !n_s8.root && cw[32];
	end

	logic sat_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s9 <= w_c;
			sat_s9 <= lsat_s8 | (|wsat);
			lsat_s9 <= lsat_s8;
		end
	end

	assign m_axis_tdata = w_s9;
	assign m_axis_tuser = sat_s9;

	`ATW_ASSERT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	`ATW_ASSERT(a_ready, clk, arst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
	`ATW_ASSERT(a_sat, clk, arst_n, m_axis_tvalid && lsat_s9 |-> m_axis_tuser)
endmodule
